// ----- sv/xor_verified_hash_table_store_assert.svh -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: assertion macros
// Concurrent assertion shorthands shared by the checkers of the block.
// ----------------------------------------------------------------------------
`ifndef XOR_VERIFIED_HASH_TABLE_STORE_ASSERT_SVH
`define XOR_VERIFIED_HASH_TABLE_STORE_ASSERT_SVH

// same-cycle implication
`define XVHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XVHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/xvht_pkg.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: package
// Shared constants, request and response types, and the saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xvht_pkg;

	localparam int INDEX_BITS_DEF = 16;

	localparam int SCORE_POS = 16;
	localparam int EVAL_POS  = 32;
	localparam int DEPTH_POS = 48;
	localparam int NODE_POS  = 56;

	localparam logic [8:0] DEPTH_MARGIN = 9'd4;
	localparam logic [7:0] NODE_MAX     = 8'd2;

	localparam logic       FUNC_PROBE = 1'b0;
	localparam logic       FUNC_SAVE  = 1'b1;
	localparam logic [1:0] NODE_PV    = 2'd0;

	typedef struct packed {
		logic               func;
		logic [63:0]        key;
		logic signed [17:0] score;
		logic signed [17:0] eval;
		logic [15:0]        move;
		logic [7:0]         depth;
		logic [1:0]         node;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic               wrote;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [1:0]         node;
		logic [15:0]        move;
	} rsp_t;

	function automatic logic [15:0] sat16(logic signed [17:0] v);
		logic [15:0] r;
		if (v[17:15] == 3'b000 || v[17:15] == 3'b111) begin
			r = v[15:0];
		end else if (v[17]) begin
			r = 16'h8000;
		end else begin
			r = 16'h7fff;
		end
		return r;
	endfunction

endpackage

// ----- sv/xvht_ram.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: slot memory
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xvht_ram #(
	parameter int ADDR_BITS = xvht_pkg::INDEX_BITS_DEF,
	parameter int DATA_BITS = 128
) (
	input  logic                 clk,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic                 we,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	output logic [DATA_BITS-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/xvht_ctrl.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: sequencer
// Clears the slot memory after reset, then reads a slot per request, checks
// the XOR signature, decides on replacement and writes the slot back when it replaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xvht_ctrl #(
	parameter int INDEX_BITS = xvht_pkg::INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_valid,
	output logic                  s_ready,
	input  xvht_pkg::req_t        req,
	output logic                  m_valid,
	input  logic                  m_ready,
	output xvht_pkg::rsp_t        rsp,
	output logic [INDEX_BITS-1:0] mem_addr,
	output logic                  mem_we,
	output logic [127:0]          mem_wdata,
	output logic                  mem_re,
	input  logic [127:0]          mem_rdata
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t                state_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic                  m_valid_q;
	xvht_pkg::rsp_t        rsp_q;
	xvht_pkg::req_t        req_q;

	logic [63:0] rd_key;
	logic [63:0] rd_data;
	logic [63:0] new_data;
	logic        hit_c;
	logic        wr_c;
	logic        out_free;
	logic        accept;

	assign accept   = s_valid && (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_ready;

	assign rd_key  = mem_rdata[127:64];
	assign rd_data = mem_rdata[63:0];

	always_comb begin
		hit_c = ((rd_key ^ rd_data) == req_q.key) &&
			(rd_data[xvht_pkg::NODE_POS +: 8] <= xvht_pkg::NODE_MAX);
		wr_c = (req_q.func == xvht_pkg::FUNC_SAVE) &&
			(req_q.node == xvht_pkg::NODE_PV || !hit_c ||
			({1'b0, req_q.depth} + xvht_pkg::DEPTH_MARGIN) >
			{1'b0, rd_data[xvht_pkg::DEPTH_POS +: 8]});
		new_data = {6'b0, req_q.node, req_q.depth,
			xvht_pkg::sat16(req_q.eval), xvht_pkg::sat16(req_q.score), req_q.move};
	end

	always_comb begin
		mem_re    = accept;
		mem_we    = 1'b0;
		mem_wdata = {req_q.key ^ new_data, new_data};
		mem_addr  = req_q.key[INDEX_BITS-1:0];
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				mem_addr  = clr_q;
			end
			ST_IDLE: begin
				mem_addr = req.key[INDEX_BITS-1:0];
			end
			ST_EVAL: begin
				mem_we = out_free && wr_c;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
			rsp_q     <= '0;
		end else begin
			if (m_valid_q && m_ready && state_q != ST_EVAL) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						m_valid_q   <= 1'b1;
						rsp_q.hit   <= hit_c;
						rsp_q.wrote <= wr_c;
						rsp_q.score <= hit_c ? rd_data[xvht_pkg::SCORE_POS +: 16] : '0;
						rsp_q.eval  <= hit_c ? rd_data[xvht_pkg::EVAL_POS +: 16] : '0;
						rsp_q.depth <= hit_c ? rd_data[xvht_pkg::DEPTH_POS +: 8] : '0;
						rsp_q.node  <= hit_c ? rd_data[xvht_pkg::NODE_POS +: 2] : '0;
						rsp_q.move  <= hit_c ? rd_data[15:0] : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = m_valid_q;
	assign rsp     = rsp_q;

endmodule

// ----- sv/xor_verified_hash_table_store.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: top level
// Direct-mapped transposition table with XOR-checked slots.
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE, which starts the read of the single-port
// slot memory, and is evaluated in ST_EVAL, which registers the result and
// any write-back once the output register is free; no new request is taken until then.
// Reset: a clearing pass writes every slot to zero with s_tready low;
// the output register is empty after reset.
`timescale 1ns / 1ps

module xor_verified_hash_table_store #(
	parameter int INDEX_BITS = xvht_pkg::INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// lookup_key[63:0], new_score[81:64], new_eval[99:82], new_move[115:100],
	// new_depth[123:116], new_node[125:124], zero[127:126]
	input  logic [127:0] s_tdata,
	// func[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_score[15:0], found_eval[31:16], found_depth[39:32],
	// found_node[41:40], found_move[57:42], zero[63:58]
	output logic [63:0]  m_tdata,
	// hit[0], wrote[1]
	output logic [1:0]   m_tuser
);

	xvht_pkg::req_t        req;
	xvht_pkg::rsp_t        rsp;
	logic [INDEX_BITS-1:0] mem_addr;
	logic                  mem_we;
	logic [127:0]          mem_wdata;
	logic                  mem_re;
	logic [127:0]          mem_rdata;

	always_comb begin
		req.func  = s_tuser;
		req.key   = s_tdata[63:0];
		req.score = s_tdata[81:64];
		req.eval  = s_tdata[99:82];
		req.move  = s_tdata[115:100];
		req.depth = s_tdata[123:116];
		req.node  = s_tdata[125:124];
	end

	assign m_tdata = {6'b0, rsp.move, rsp.node, rsp.depth, rsp.eval, rsp.score};
	assign m_tuser = {rsp.wrote, rsp.hit};

	xvht_ctrl #(
		.INDEX_BITS(INDEX_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.req      (req),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.rsp      (rsp),
		.mem_addr (mem_addr),
		.mem_we   (mem_we),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_rdata(mem_rdata)
	);

	xvht_ram #(
		.ADDR_BITS(INDEX_BITS),
		.DATA_BITS(128)
	) u_ram (
		.clk  (clk),
		.addr (mem_addr),
		.we   (mem_we),
		.wdata(mem_wdata),
		.re   (mem_re),
		.rdata(mem_rdata)
	);

endmodule

// ----- sv/xvht_checker.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xor_verified_hash_table_store_assert.svh"

module xvht_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [127:0] s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	logic s_seen;
	assign s_seen = s_tvalid && s_tready && (s_tdata[127:126] == 2'b00 || s_tuser);

	`XVHT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`XVHT_ASSERT_NEXT(a_one_inflight, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while one is in flight")
	`XVHT_ASSERT_IMPL(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == 64'd0, "miss with nonzero fields")
	`XVHT_ASSERT_IMPL(a_hit_node, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[41:40] != 2'b11 && m_tdata[63:58] == 6'd0, "hit with invalid node type")
	`XVHT_ASSERT_NEXT(a_seen_busy, clk, arst_n, s_seen, !s_tready, "ready during evaluation")

endmodule

bind xor_verified_hash_table_store xvht_checker u_xvht_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// XOR-verified hash table store: testbench
// Drives probe and save requests into the table over the request stream and
// checks every response against a cycle-free model of the slot memory that
// applies the same XOR check, replacement rule, saturation and packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_INDEX_BITS = xvht_pkg::INDEX_BITS_DEF;
	localparam int IDLE_LIMIT       = 200000;
	localparam int HOLDOFF_CYCLES   = 400;
	localparam int HOT_KEY_COUNT    = 24;
	localparam int RANDOM_PHASE_LEN = 160;

	localparam logic [1:0] NODE_CUT     = 2'd1;
	localparam logic [1:0] NODE_ALL     = 2'd2;
	localparam logic [1:0] NODE_INVALID = 2'd3;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PATTERN
	} ready_mode_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;

	logic [63:0]    slot_keys [int unsigned];
	logic [63:0]    slot_data [int unsigned];
	xvht_pkg::rsp_t predicted_responses [$];
	logic [63:0]    hot_keys [HOT_KEY_COUNT];

	ready_mode_t    ready_mode;
	logic           holdoff_start;
	int             hold_left;
	int             pattern_phase;
	bit             gaps_enabled;
	int             burst_left;
	int             idle_cycles;
	int             mismatches;
	int             probes_sent;
	int             saves_sent;
	int             hits_seen;
	int             writes_seen;
	xvht_pkg::rsp_t head_response;
	xvht_pkg::rsp_t got_response;

	xor_verified_hash_table_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] clamp_to_s16(logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'h7fff;
		end else if (v < -18'sd32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic xvht_pkg::rsp_t predict_table_access(xvht_pkg::req_t r);
		int unsigned    slot;
		logic [63:0]    old_key;
		logic [63:0]    old_data;
		logic [63:0]    new_data;
		logic [8:0]     deeper;
		xvht_pkg::rsp_t rsp;
		slot     = 32'(r.key[TABLE_INDEX_BITS-1:0]);
		old_key  = slot_keys.exists(slot) ? slot_keys[slot] : 64'd0;
		old_data = slot_data.exists(slot) ? slot_data[slot] : 64'd0;
		rsp      = '0;
		rsp.hit  = ((old_key ^ old_data) == r.key) && (old_data[63:56] <= 8'd2);
		if (r.func == xvht_pkg::FUNC_SAVE) begin
			deeper = {1'b0, r.depth} + 9'd4;
			if (r.node == xvht_pkg::NODE_PV || !rsp.hit ||
				deeper > {1'b0, old_data[55:48]}) begin
				new_data = {6'd0, r.node, r.depth, clamp_to_s16(r.eval),
					clamp_to_s16(r.score), r.move};
				slot_data[slot] = new_data;
				slot_keys[slot] = r.key ^ new_data;
				rsp.wrote = 1'b1;
			end
		end
		if (rsp.hit) begin
			rsp.score = old_data[31:16];
			rsp.eval  = old_data[47:32];
			rsp.depth = old_data[55:48];
			rsp.node  = old_data[57:56];
			rsp.move  = old_data[15:0];
		end
		return rsp;
	endfunction

	function automatic xvht_pkg::req_t make_req(logic func, logic [63:0] key, int score,
		int eval, int move, int depth, logic [1:0] node);
		xvht_pkg::req_t r;
		r.func  = func;
		r.key   = key;
		r.score = 18'(score);
		r.eval  = 18'(eval);
		r.move  = 16'(move);
		r.depth = 8'(depth);
		r.node  = node;
		return r;
	endfunction

	function automatic int random_score();
		int picks [6] = '{131071, -131072, 32767, 32768, -32768, -32769};
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 262143) - 131072;
			3: return picks[$urandom_range(0, 5)];
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic xvht_pkg::req_t random_request();
		logic [63:0] key;
		logic [1:0]  node;
		if ($urandom_range(0, 3) == 0) begin
			key = {$urandom(), $urandom()};
		end else begin
			key = hot_keys[$urandom_range(0, HOT_KEY_COUNT - 1)];
		end
		node = ($urandom_range(0, 9) == 0) ? NODE_INVALID : 2'($urandom_range(0, 2));
		return make_req(1'($urandom_range(0, 1)), key, random_score(), random_score(),
			$urandom_range(0, 65535), $urandom_range(0, 255), node);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(xvht_pkg::req_t r);
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(1, 7)) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
				end
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, r.node, r.depth, r.move, r.eval, r.score, r.key};
		s_tuser  <= r.func;
		do @(posedge clk); while (!s_tready);
		predicted_responses.push_back(predict_table_access(r));
		if (r.func == xvht_pkg::FUNC_SAVE) saves_sent++;
		else probes_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (predicted_responses.size() == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_request(make_req(xvht_pkg::FUNC_PROBE, 64'd0, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_PROBE, '1, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_PROBE, {$urandom(), $urandom()}, 0, 0, 0, 0,
			xvht_pkg::NODE_PV));
		wait_for_results();
	endtask

	task automatic test_save_and_probe();
		logic [63:0] key_a;
		key_a = 64'hA5A5_0F0F_F0F0_1234;
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_a, 131071, -131072, 65535, 255,
			NODE_CUT));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_a, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_a, 5, 5, 1, 0, NODE_ALL));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_a, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_a, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_SAVE, 64'h5A5A_F0F0_0F0F_0001, 32767, -32768,
			7, 3, NODE_ALL));
		send_request(make_req(xvht_pkg::FUNC_SAVE, 64'h5A5A_F0F0_0F0F_0001, 32768, -32769,
			8, 200, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_PROBE, 64'h5A5A_F0F0_0F0F_0001, 0, 0, 0, 0,
			xvht_pkg::NODE_PV));
		wait_for_results();
	endtask

	task automatic test_invalid_node();
		logic [63:0] key_c;
		key_c = 64'hFFFF_0000_FFFF_BEEF;
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_c, -1, 1, 4660, 40, NODE_INVALID));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_c, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_c, 2, -2, 22, 0, NODE_CUT));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_c, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		wait_for_results();
	endtask

	task automatic test_high_key_bits();
		logic [63:0] key_d;
		key_d = 64'h0123_4567_89AB_CDEF;
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_d, 100, -100, 9, 30, NODE_CUT));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_d ^ 64'h8000_0000_0000_0000,
			0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_d ^ 64'h0000_0001_0000_0000,
			1, 1, 1, 0, NODE_ALL));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_d, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		wait_for_results();
	endtask

	task automatic test_depth_margin();
		logic [63:0] key_e;
		key_e = 64'hDEAD_BEEF_0000_7777;
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_e, 10, 10, 10, 10, NODE_CUT));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_e, 6, 6, 6, 6, NODE_ALL));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_e, 7, 7, 7, 7, NODE_ALL));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_e, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_SAVE, key_e, 3, 3, 3, 2, xvht_pkg::NODE_PV));
		send_request(make_req(xvht_pkg::FUNC_PROBE, key_e, 0, 0, 0, 0, xvht_pkg::NODE_PV));
		wait_for_results();
	endtask

	task automatic test_receiver_holdoff();
		gaps_enabled = 1'b0;
		ready_mode   = READY_RANDOM;
		@(posedge clk);
		holdoff_start = 1'b1;
		repeat (40) send_request(random_request());
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gaps_enabled = 1'b1; ready_mode = READY_RANDOM; end
				1: begin gaps_enabled = 1'b0; ready_mode = READY_ALWAYS; end
				2: begin gaps_enabled = 1'b1; ready_mode = READY_PATTERN; end
				default: begin gaps_enabled = 1'b1; ready_mode = READY_ALWAYS; end
			endcase
			for (int n = 0; n < RANDOM_PHASE_LEN; n++) begin
				send_request(random_request());
				if (n == RANDOM_PHASE_LEN / 2) wait_for_results();
			end
			wait_for_results();
		end
	endtask

	always @(negedge clk) begin
		if (holdoff_start) begin
			hold_left     = HOLDOFF_CYCLES;
			holdoff_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				READY_PATTERN: begin
					pattern_phase++;
					m_tready <= ((pattern_phase % 5) < 3);
				end
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_response.hit   = m_tuser[0];
			got_response.wrote = m_tuser[1];
			got_response.score = m_tdata[15:0];
			got_response.eval  = m_tdata[31:16];
			got_response.depth = m_tdata[39:32];
			got_response.node  = m_tdata[41:40];
			got_response.move  = m_tdata[57:42];
			if (got_response.hit) hits_seen++;
			if (got_response.wrote) writes_seen++;
			if (predicted_responses.size() == 0) begin
				report_mismatch("response with none pending", m_tdata, 64'd0);
			end else begin
				head_response = predicted_responses.pop_front();
				if (got_response.hit !== head_response.hit)
					report_mismatch("hit", 64'(got_response.hit),
						64'(head_response.hit));
				if (got_response.wrote !== head_response.wrote)
					report_mismatch("wrote", 64'(got_response.wrote),
						64'(head_response.wrote));
				if (got_response.score !== head_response.score)
					report_mismatch("found_score", 64'(got_response.score),
						64'(head_response.score));
				if (got_response.eval !== head_response.eval)
					report_mismatch("found_eval", 64'(got_response.eval),
						64'(head_response.eval));
				if (got_response.depth !== head_response.depth)
					report_mismatch("found_depth", 64'(got_response.depth),
						64'(head_response.depth));
				if (got_response.node !== head_response.node)
					report_mismatch("found_node", 64'(got_response.node),
						64'(head_response.node));
				if (got_response.move !== head_response.move)
					report_mismatch("found_move", 64'(got_response.move),
						64'(head_response.move));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = xvht_pkg::FUNC_PROBE;
		m_tready      = 1'b0;
		ready_mode    = READY_ALWAYS;
		holdoff_start = 1'b0;
		hold_left     = 0;
		pattern_phase = 0;
		gaps_enabled  = 1'b0;
		burst_left    = 0;
		idle_cycles   = 0;
		mismatches    = 0;
		probes_sent   = 0;
		saves_sent    = 0;
		hits_seen     = 0;
		writes_seen   = 0;
		hot_keys[0]   = 64'd0;
		for (int i = 1; i < HOT_KEY_COUNT; i++) begin
			hot_keys[i] = {$urandom(), $urandom()};
			if (i % 3 != 0) hot_keys[i][15:0] = hot_keys[i - 1][15:0];
		end
		hot_keys[HOT_KEY_COUNT - 1][15:0] = 16'hffff;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_save_and_probe();
		test_invalid_node();
		test_high_key_bits();
		test_depth_margin();
		test_receiver_holdoff();
		test_random_traffic();

		wait_for_results();
		$display("covered %0d probes and %0d saves, %0d hits and %0d slot writes seen",
			probes_sent, saves_sent, hits_seen, writes_seen);
		$display("with bursty requests, stalled and held-off responses, %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
